### hdl/ede_pkg.sv
package ede_pkg;

  localparam int DIST_W = 7;
  localparam int SYM_W  = 8;
  localparam int FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_APPEND_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE       = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
  } req_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } rsp_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

endpackage

### hdl/ede_string_store.sv
module ede_string_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic [ede_pkg::SYM_W-1:0] wdata,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr,
  output logic [ede_pkg::SYM_W-1:0] rdata
);

  logic [ede_pkg::SYM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds between reads, so one read of the second string serves a whole row pass.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/ede_dp_core.sv
module ede_dp_core #(
  parameter int MAX_LEN = 64,
  parameter int LEN_W   = 7,
  parameter int ADDR_W  = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [LEN_W-1:0]          m_len,
  input  logic [LEN_W-1:0]          n_len,
  input  logic                      out_free,
  output ede_pkg::core_status_t     status,
  output logic [LEN_W-1:0]          result,
  output logic                      a_re,
  output logic [ADDR_W-1:0]         a_raddr,
  input  logic [ede_pkg::SYM_W-1:0] a_rdata,
  output logic                      b_re,
  output logic [ADDR_W-1:0]         b_raddr,
  input  logic [ede_pkg::SYM_W-1:0] b_rdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOADB = 2'd1;
  localparam logic [1:0] ST_ROW   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state;
  logic [ADDR_W-1:0] c;
  logic [ADDR_W-1:0] r;
  logic [LEN_W-1:0]  m_reg;
  logic [LEN_W-1:0]  n_reg;
  logic [LEN_W-1:0]  left;
  logic [LEN_W-1:0]  diag;

  logic [LEN_W-1:0]  cost_mem [MAX_LEN];
  logic [LEN_W-1:0]  cost_rdata;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              sub;
  logic [LEN_W-1:0]  above;
  logic [LEN_W:0]    left_inc;
  logic [LEN_W:0]    above_inc;
  logic [LEN_W:0]    diag_sum;
  logic [LEN_W:0]    min_ab;
  logic [LEN_W:0]    min_all;
  logic [LEN_W-1:0]  cell_cost;
  logic              last_cell;
  logic              last_row;

  assign last_cell = (LEN_W'(c) + LEN_W'(1)) == m_reg;
  assign last_row  = (LEN_W'(r) + LEN_W'(1)) == n_reg;

  // The read for the next cell is issued while the current cell is written
  // one entry lower, so the same entry is never read and written in a cycle.
  assign rd_en   = (state == ST_LOADB) || ((state == ST_ROW) && !last_cell);
  assign rd_addr = (state == ST_LOADB) ? '0 : c + ADDR_W'(1);

  assign a_re    = rd_en;
  assign a_raddr = rd_addr;
  assign b_re    = (state == ST_LOADB);
  assign b_raddr = r;

  // On the first row the previous row is the initial one, cost i at column i.
  assign sub       = (a_rdata != b_rdata);
  assign above     = (r == '0) ? (LEN_W'(c) + LEN_W'(1)) : cost_rdata;
  assign left_inc  = {1'b0, left} + (LEN_W+1)'(1);
  assign above_inc = {1'b0, above} + (LEN_W+1)'(1);
  assign diag_sum  = {1'b0, diag} + (LEN_W+1)'(sub);
  assign min_ab    = (left_inc < above_inc) ? left_inc : above_inc;
  assign min_all   = (min_ab < diag_sum) ? min_ab : diag_sum;
  assign cell_cost = min_all[LEN_W-1:0];

  assign status.busy = (state != ST_IDLE);
  assign status.done = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cost_rdata <= cost_mem[rd_addr];
    end
    if (state == ST_ROW) begin
      cost_mem[c] <= cell_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            if ((m_len == '0) || (n_len == '0)) begin
              state <= ST_DONE;
            end else begin
              state <= ST_LOADB;
            end
          end
        end
        ST_LOADB: begin
          state <= ST_ROW;
        end
        ST_ROW: begin
          if (last_cell) begin
            state <= last_row ? ST_DONE : ST_LOADB;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        m_reg <= m_len;
        n_reg <= n_len;
        r     <= '0;
        // With one string empty the distance is the other length.
        result <= m_len | n_len;
      end
      ST_LOADB: begin
        c    <= '0;
        left <= LEN_W'(r) + LEN_W'(1);
        diag <= LEN_W'(r);
      end
      ST_ROW: begin
        left <= cell_cost;
        diag <= above;
        if (last_cell) begin
          if (last_row) begin
            result <= cell_cost;
          end else begin
            r <= r + ADDR_W'(1);
          end
        end else begin
          c <= c + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/edit_distance_engine_top.sv
// Append words give no result; words are taken only while the core is idle.
// Compute: the result follows the DP row pass, which runs one cell per cycle
// through the cost row memory; when either string is empty no row pass runs.
// One compute is in work at a time.
// Synchronous active-high reset clears the lengths, the overflow flag and the
// sequencer; the string stores and the cost row need no clearing.
module edit_distance_engine_top #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ede_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ede_pkg::rsp_word_t rsp
);

  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW     = ede_pkg::DIST_W;

  logic [LEN_W-1:0]          first_length;
  logic [LEN_W-1:0]          second_length;
  logic                      overflow_seen;
  logic                      overflow_hold;

  logic                      accept;
  logic                      app_a;
  logic                      app_b;
  logic                      room_a;
  logic                      room_b;
  logic                      start;
  logic                      out_free;
  ede_pkg::core_status_t     status;
  logic [LEN_W-1:0]          result;

  logic                      a_re;
  logic [ADDR_W-1:0]         a_raddr;
  logic [ede_pkg::SYM_W-1:0] a_rdata;
  logic                      b_re;
  logic [ADDR_W-1:0]         b_raddr;
  logic [ede_pkg::SYM_W-1:0] b_rdata;

  assign req_ready = !status.busy;
  assign accept    = req_valid && req_ready;
  assign app_a     = accept && (req.func == ede_pkg::FUNC_APPEND_FIRST);
  assign app_b     = accept && (req.func == ede_pkg::FUNC_APPEND_SECOND);
  assign start     = accept && (req.func == ede_pkg::FUNC_COMPUTE);
  assign room_a    = (first_length != LEN_W'(MAX_LEN));
  assign room_b    = (second_length != LEN_W'(MAX_LEN));
  assign out_free  = !rsp_valid || rsp_ready;

  ede_string_store #(.DEPTH(MAX_LEN), .ADDR_W(ADDR_W)) u_first (
    .clk   (clk),
    .we    (app_a && room_a),
    .waddr (first_length[ADDR_W-1:0]),
    .wdata (req.symbol),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  ede_string_store #(.DEPTH(MAX_LEN), .ADDR_W(ADDR_W)) u_second (
    .clk   (clk),
    .we    (app_b && room_b),
    .waddr (second_length[ADDR_W-1:0]),
    .wdata (req.symbol),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  ede_dp_core #(.MAX_LEN(MAX_LEN), .LEN_W(LEN_W), .ADDR_W(ADDR_W)) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .m_len    (first_length),
    .n_len    (second_length),
    .out_free (out_free),
    .status   (status),
    .result   (result),
    .a_re     (a_re),
    .a_raddr  (a_raddr),
    .a_rdata  (a_rdata),
    .b_re     (b_re),
    .b_raddr  (b_raddr),
    .b_rdata  (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (app_a) begin
        if (room_a) begin
          first_length <= first_length + LEN_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (app_b) begin
        if (room_b) begin
          second_length <= second_length + LEN_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (start) begin
        first_length  <= '0;
        second_length <= '0;
        overflow_seen <= 1'b0;
      end
      if (status.done && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      overflow_hold <= overflow_seen;
    end
    if (status.done && out_free) begin
      rsp.distance <= DW'(result);
      rsp.overflow <= overflow_hold;
    end
  end

endmodule

### hdl/ede_checker.sv
module ede_checker #(
  parameter int MAX_LEN = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input ede_pkg::req_word_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input ede_pkg::rsp_word_t rsp
);

  // A result word that is not taken stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("result word dropped or changed while stalled");

  // An append never produces a result word.
  a_append_silent: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.func != ede_pkg::FUNC_COMPUTE) && !rsp_valid)
    |=> !rsp_valid)
    else $error("result word after an append");

  // A compute holds off further words while the row passes run.
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.func == ede_pkg::FUNC_COMPUTE)) |=> !req_ready)
    else $error("word accepted right after a compute");

  // The distance never exceeds the store capacity.
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.distance) <= 32'(MAX_LEN)))
    else $error("distance out of range");

endmodule

bind edit_distance_engine_top ede_checker #(.MAX_LEN(MAX_LEN)) u_ede_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

### tb/sv/edit_distance_checker.sv
module edit_distance_checker #(
  parameter int MAX_LEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  ede_pkg::req_word_t  req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  ede_pkg::rsp_word_t  rsp,
  output int unsigned         mismatches,
  output int unsigned         results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYM_W  = ede_pkg::SYM_W;
  localparam int DIST_W = ede_pkg::DIST_W;

  logic [SYM_W-1:0]   first_str [MAX_LEN];
  logic [SYM_W-1:0]   second_str [MAX_LEN];
  int unsigned        first_len;
  int unsigned        second_len;
  logic               overflow_seen;
  ede_pkg::rsp_word_t expected_q [$];

  initial begin
    mismatches   = 0;
    results_owed = 0;
  end

  // Single-row Levenshtein pass over the first string, one row per second-string symbol.
  function automatic logic [DIST_W-1:0] levenshtein();
    int unsigned row [MAX_LEN+1];
    int unsigned diag;
    int unsigned above;
    int unsigned best;
    for (int i = 0; i <= first_len; i++) row[i] = i;
    for (int j = 1; j <= second_len; j++) begin
      diag   = row[0];
      row[0] = j;
      for (int i = 1; i <= first_len; i++) begin
        above = row[i];
        best  = diag + (first_str[i-1] != second_str[j-1]);
        if (row[i-1] + 1 < best) best = row[i-1] + 1;
        if (above + 1 < best) best = above + 1;
        row[i] = best;
        diag   = above;
      end
    end
    return row[first_len][DIST_W-1:0];
  endfunction

  task automatic apply_word(input ede_pkg::req_word_t w);
    ede_pkg::rsp_word_t want;
    case (w.func)
      ede_pkg::FUNC_APPEND_FIRST: begin
        if (first_len >= MAX_LEN) begin
          overflow_seen = 1'b1;
        end else begin
          first_str[first_len] = w.symbol;
          first_len++;
        end
      end
      ede_pkg::FUNC_APPEND_SECOND: begin
        if (second_len >= MAX_LEN) begin
          overflow_seen = 1'b1;
        end else begin
          second_str[second_len] = w.symbol;
          second_len++;
        end
      end
      ede_pkg::FUNC_COMPUTE: begin
        want.distance = levenshtein();
        want.overflow = overflow_seen;
        expected_q    = {expected_q, want};
        first_len     = 0;
        second_len    = 0;
        overflow_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    ede_pkg::rsp_word_t want;
    if (rst) begin
      first_len     = 0;
      second_len    = 0;
      overflow_seen = 1'b0;
      expected_q.delete();
    end else begin
      // A result word is always older than a compute word taken at the same edge.
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: distance %0d overflow %0b", rsp.distance,
                 rsp.overflow);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, rsp.distance);
            mismatches++;
          end
          if (rsp.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, rsp.overflow);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) apply_word(req);
    end
    results_owed <= expected_q.size();
  end

endmodule

### tb/sv/edit_distance_engine_top_tb.sv
module edit_distance_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN       = 64;
  localparam int WORD_TARGET   = 1250;
  localparam int PRESSURE_HOLD = 400;
  localparam int SYM_W         = ede_pkg::SYM_W;
  localparam int FUNC_W        = ede_pkg::FUNC_W;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  ede_pkg::req_word_t req       = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  ede_pkg::rsp_word_t rsp;

  int unsigned mismatches;
  int unsigned results_owed;
  int unsigned words_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;

  edit_distance_engine_top #(
    .MAX_LEN(MAX_LEN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  edit_distance_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .results_owed(results_owed)
  );

  always begin
    #5;
    clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_taken) begin
      hold_taken <= hold_req;
      hold_left  <= PRESSURE_HOLD;
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{func: f, symbol: s};
    do @(posedge clk); while (!req_ready);
    if (f != FUNC_UNUSED) words_sent++;
  endtask

  function automatic int unsigned rand_len();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return $urandom_range(8);
    if (pick < 95) return $urandom_range(24, 9);
    return $urandom_range(70, 56);
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol(input logic [SYM_W-1:0] base,
                                                   input bit narrow);
    // A narrow alphabet makes matching symbols common, so the diagonal path gets used.
    if (narrow) return base + SYM_W'($urandom_range(3));
    return SYM_W'($urandom_range(255));
  endfunction

  // Loads two strings with the appends interleaved at random, then asks for the distance.
  task automatic run_pair(input int unsigned len_a, input int unsigned len_b, input bit narrow);
    int unsigned      left_a;
    int unsigned      left_b;
    logic [SYM_W-1:0] base;
    base   = SYM_W'($urandom_range(255));
    left_a = len_a;
    left_b = len_b;
    while (left_a + left_b > 0) begin
      if ($urandom_range(99) < 4) send_word(FUNC_UNUSED, SYM_W'($urandom_range(255)));
      if (left_a > 0 && (left_b == 0 || $urandom_range(1) == 1)) begin
        send_word(ede_pkg::FUNC_APPEND_FIRST, pick_symbol(base, narrow));
        left_a--;
      end else begin
        send_word(ede_pkg::FUNC_APPEND_SECOND, pick_symbol(base, narrow));
        left_b--;
      end
    end
    send_word(ede_pkg::FUNC_COMPUTE, SYM_W'($urandom_range(255)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Both strings empty.
    send_word(ede_pkg::FUNC_COMPUTE, 8'h00);
    // Only the first string loaded, symbol extremes.
    send_word(ede_pkg::FUNC_APPEND_FIRST, 8'h00);
    send_word(ede_pkg::FUNC_APPEND_FIRST, 8'hFF);
    send_word(ede_pkg::FUNC_COMPUTE, 8'hFF);
    // Only the second string loaded.
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'hFF);
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'h00);
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'h55);
    send_word(ede_pkg::FUNC_COMPUTE, 8'hAA);
    // Identical strings.
    send_word(ede_pkg::FUNC_APPEND_FIRST, 8'h61);
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'h61);
    send_word(ede_pkg::FUNC_APPEND_FIRST, 8'h62);
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'h62);
    send_word(ede_pkg::FUNC_COMPUTE, 8'h00);
    // The unused function code must leave everything alone.
    send_word(FUNC_UNUSED, 8'hAA);
    // One substitution.
    send_word(ede_pkg::FUNC_APPEND_FIRST, 8'h6B);
    send_word(ede_pkg::FUNC_APPEND_FIRST, 8'h69);
    send_word(ede_pkg::FUNC_APPEND_FIRST, 8'h74);
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'h73);
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'h69);
    send_word(ede_pkg::FUNC_APPEND_SECOND, 8'h74);
    send_word(ede_pkg::FUNC_COMPUTE, 8'h00);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
        1: begin send_idle_pct = 63; rsp_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct <= 63; end
        default: begin send_idle_pct = 14; rsp_stall_pct <= 14; end
      endcase
      if (phase == 0) begin
        // Full stores on either side, so appends get refused.
        run_pair(MAX_LEN + 1, 5, 1'b0);
        run_pair(4, MAX_LEN + 2, 1'b1);
        // Hold the result side off while short pairs keep coming, to back the block up.
        hold_req <= hold_req + 1;
        repeat (6) run_pair($urandom_range(4), $urandom_range(4), 1'b1);
      end
      while (words_sent < (phase + 1) * WORD_TARGET / 4)
        run_pair(rand_len(), rand_len(), $urandom_range(99) < 70);
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
